// File: hw/rtl/sdpc_pkg.sv
// ----------------------------------------------------------------------------
// sdpc_pkg: shared types and constants for the stepper driver pin control
// Item formats, command codes, register indexes, the potentiometer channel
// map and the sizes shared by the front, the queue and the back end.
// ----------------------------------------------------------------------------
package sdpc_pkg;

	// Defaults and limits of the top-level parameters.
	localparam int NUM_AXES_DEF     = 5;
	localparam int CHANNEL_BITS_DEF = 3;
	localparam int VALUE_BITS_DEF   = 8;
	localparam int CHANNEL_BITS_MAX = 4;
	localparam int VALUE_BITS_MAX   = 10;
	localparam int FRAME_W_MAX      = CHANNEL_BITS_MAX + VALUE_BITS_MAX;
	localparam int BIT_CNT_W        = $clog2(FRAME_W_MAX);

	localparam int QUEUE_DEPTH = 4;
	localparam int PIN_W       = 5;
	localparam int MOTOR_AXES  = 5;

	// Command codes.
	localparam logic [2:0] MODE_SET_OPTIONS = 3'd0;
	localparam logic [2:0] MODE_ENABLE      = 3'd1;
	localparam logic [2:0] MODE_DIRECTION   = 3'd2;
	localparam logic [2:0] MODE_STEP        = 3'd3;
	localparam logic [2:0] MODE_CLEAR_STEPS = 3'd4;

	// The extra current channel that has no motor pins.
	localparam logic [2:0] AXIS_EXTRA  = 3'd6;
	localparam logic [2:0] CHAN_EXTRA  = 3'd4;
	localparam logic [2:0] USTEP_LIMIT = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SCK_HALF_PERIOD   = 2'd0;
	localparam logic [1:0] CFG_SELECT_SETUP_TIME = 2'd1;

	localparam logic [15:0] SCK_HALF_PERIOD_RST   = 16'd512;
	localparam logic [15:0] SELECT_SETUP_TIME_RST = 16'd10000;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] axis;
		logic [2:0] ustep_bits;
		logic [7:0] current;
		logic       level;
	} cmd_item_t;

	typedef struct packed {
		logic [4:0] ms1_pins;
		logic [4:0] ms2_pins;
		logic [4:0] enable_n_pins;
		logic [4:0] dir_pins;
		logic [4:0] step_pins;
		logic       frame_bit;
		logic       frame_valid;
		logic       last;
	} res_item_t;

	typedef struct packed {
		logic [PIN_W-1:0] ms1;
		logic [PIN_W-1:0] ms2;
		logic [PIN_W-1:0] enable_n;
		logic [PIN_W-1:0] dir;
		logic [PIN_W-1:0] step;
	} pins_t;

	// One classified command waiting for the back end.
	typedef struct packed {
		pins_t                  pins;
		logic                   is_frame;
		logic [FRAME_W_MAX-1:0] frame;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [15:0] sck_half_period;
		logic [15:0] select_setup_time;
	} timing_t;

	function automatic logic [2:0] chan_of_axis(input logic [2:0] axis);
		logic [2:0] chan;
		case (axis)
			3'd0: chan = 3'd3;
			3'd1: chan = 3'd1;
			3'd2: chan = 3'd0;
			3'd3: chan = 3'd2;
			3'd4: chan = 3'd5;
			default: chan = CHAN_EXTRA;
		endcase
		return chan;
	endfunction

endpackage

// File: hw/rtl/sdpc_front.sv
// ----------------------------------------------------------------------------
// sdpc_front: command decode and pin state
// Accepts commands, updates the pin registers in command order and builds
// one job per command for the back end.
// ----------------------------------------------------------------------------
module sdpc_front #(
	parameter int NUM_AXES     = sdpc_pkg::NUM_AXES_DEF,
	parameter int CHANNEL_BITS = sdpc_pkg::CHANNEL_BITS_DEF,
	parameter int VALUE_BITS   = sdpc_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  sdpc_pkg::cmd_item_t cmd,
	input  sdpc_pkg::q_status_t q_status,
	output logic                push,
	output sdpc_pkg::job_t      push_job
);
	import sdpc_pkg::*;

	localparam int AXES_LIM_I = (NUM_AXES < MOTOR_AXES) ? NUM_AXES : MOTOR_AXES;
	localparam logic [3:0] AXES_LIM = 4'(AXES_LIM_I);
	localparam int MASK_I = (1 << NUM_AXES) - 1;
	localparam logic [PIN_W-1:0] PIN_MASK = PIN_W'(MASK_I);

	pins_t pins_q;
	pins_t pins_d;
	logic motor;
	logic is_frame;
	logic [PIN_W-1:0] bitm;
	logic [2:0] chan3;
	logic [CHANNEL_BITS-1:0] chan_v;
	logic [VALUE_BITS-1:0] cur_v;

	assign cmd_ready = !q_status.full;
	assign push = cmd_valid && cmd_ready;

	always_comb begin
		motor = ({1'b0, cmd.axis} < AXES_LIM);
		bitm = (PIN_W'(1) << cmd.axis) & PIN_MASK;
		pins_d = pins_q;
		is_frame = 1'b0;
		case (cmd.mode)
			MODE_SET_OPTIONS: begin
				if (motor || cmd.axis == AXIS_EXTRA) begin
					is_frame = 1'b1;
				end
				if (motor && cmd.ustep_bits < USTEP_LIMIT) begin
					pins_d.ms1 = cmd.ustep_bits[0] ? (pins_q.ms1 | bitm) : (pins_q.ms1 & ~bitm);
					pins_d.ms2 = cmd.ustep_bits[1] ? (pins_q.ms2 | bitm) : (pins_q.ms2 & ~bitm);
				end
			end
			MODE_ENABLE: begin
				if (motor) begin
					pins_d.enable_n = cmd.level ? (pins_q.enable_n & ~bitm)
						: (pins_q.enable_n | bitm);
				end
			end
			MODE_DIRECTION: begin
				if (motor) begin
					pins_d.dir = cmd.level ? (pins_q.dir | bitm) : (pins_q.dir & ~bitm);
				end
			end
			MODE_STEP: begin
				if (motor) begin
					pins_d.step = pins_q.step | bitm;
				end
			end
			MODE_CLEAR_STEPS: begin
				pins_d.step = '0;
			end
			default: begin
			end
		endcase

		chan3 = motor ? chan_of_axis(cmd.axis) : CHAN_EXTRA;
		chan_v = CHANNEL_BITS'(chan3);
		cur_v = VALUE_BITS'(cmd.current);

		push_job.pins = pins_d;
		push_job.is_frame = is_frame;
		push_job.frame = FRAME_W_MAX'({chan_v, cur_v});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q.ms1 <= '0;
			pins_q.ms2 <= '0;
			pins_q.enable_n <= PIN_MASK;
			pins_q.dir <= '0;
			pins_q.step <= '0;
		end else if (push) begin
			pins_q <= pins_d;
		end
	end

endmodule

// File: hw/rtl/sdpc_queue.sv
// ----------------------------------------------------------------------------
// sdpc_queue: job queue between front and back end
// A small first-in first-out store of classified commands.
// ----------------------------------------------------------------------------
module sdpc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sdpc_pkg::job_t      push_job,
	input  logic                pop,
	output sdpc_pkg::job_t      head,
	output sdpc_pkg::q_status_t q_status
);
	import sdpc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head = entries_q[rd_ptr_q];
	assign q_status.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/sdpc_back.sv
// ----------------------------------------------------------------------------
// sdpc_back: result item generator and frame serializer
// Turns each job into its result items: one pin item, or a paced serial
// frame of channel and current bits, most significant bit first.
// ----------------------------------------------------------------------------
module sdpc_back #(
	parameter int CHANNEL_BITS = sdpc_pkg::CHANNEL_BITS_DEF,
	parameter int VALUE_BITS   = sdpc_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdpc_pkg::job_t      head,
	input  sdpc_pkg::q_status_t q_status,
	output logic                pop,
	input  sdpc_pkg::timing_t   timing,
	output logic                res_valid,
	input  logic                res_ready,
	output sdpc_pkg::res_item_t res
);
	import sdpc_pkg::*;

	localparam logic [BIT_CNT_W-1:0] LAST_IDX = BIT_CNT_W'(CHANNEL_BITS + VALUE_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_BITS  = 3'b100
	} back_state_t;

	back_state_t state_q;
	job_t job_q;
	logic [BIT_CNT_W-1:0] bit_idx_q;
	logic [15:0] wait_q;
	res_item_t res_q;
	logic res_valid_q;
	logic free;
	logic wait_done;
	logic emit;

	assign res_valid = res_valid_q;
	assign res = res_q;
	assign free = !res_valid_q || res_ready;
	assign wait_done = (wait_q <= 16'd1);
	assign pop = (state_q == ST_IDLE) && !q_status.empty && (head.is_frame || free);
	// A new item enters the output register for a pin job or a due frame bit.
	assign emit = (pop && !head.is_frame) || (state_q == ST_BITS && wait_done && free);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop) begin
			job_q <= head;
			if (!head.is_frame) begin
				res_q <= '{ms1_pins: head.pins.ms1, ms2_pins: head.pins.ms2,
					enable_n_pins: head.pins.enable_n, dir_pins: head.pins.dir,
					step_pins: head.pins.step, frame_bit: 1'b0, frame_valid: 1'b0,
					last: 1'b1};
			end
		end else if (state_q == ST_BITS && wait_done && free) begin
			res_q <= '{ms1_pins: job_q.pins.ms1, ms2_pins: job_q.pins.ms2,
				enable_n_pins: job_q.pins.enable_n, dir_pins: job_q.pins.dir,
				step_pins: job_q.pins.step, frame_bit: job_q.frame[bit_idx_q],
				frame_valid: 1'b1, last: (bit_idx_q == '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_idx_q <= '0;
			wait_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit || (res_valid_q && !res_ready);
			case (state_q)
				ST_IDLE: begin
					if (pop && head.is_frame) begin
						state_q <= ST_SETUP;
						wait_q <= timing.select_setup_time;
						bit_idx_q <= LAST_IDX;
					end
				end
				ST_SETUP: begin
					if (wait_done) begin
						state_q <= ST_BITS;
						wait_q <= timing.sck_half_period;
					end else begin
						wait_q <= wait_q - 16'd1;
					end
				end
				ST_BITS: begin
					if (!wait_done) begin
						wait_q <= wait_q - 16'd1;
					end else if (free) begin
						if (bit_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							bit_idx_q <= bit_idx_q - BIT_CNT_W'(1);
							wait_q <= timing.sck_half_period;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/stepper_driver_pin_control.sv
// ----------------------------------------------------------------------------
// stepper_driver_pin_control: stepper driver pins and current frame sender
// Keeps the per-axis microstep, enable, direction and step pins and sends
// current settings to a multi-channel digital potentiometer.
// ----------------------------------------------------------------------------
// Commands enter on the cmd channel and results leave on the res channel,
// both valid/ready. The cfg channel writes the serial clock half period
// (index 0) and the chip select setup time (index 1); it is always ready.
// A command is decoded and applied to the pin registers in the cycle it is
// accepted, then queued as a job (four deep) for the back end.
// Every command except a valid set options yields one pin item through the
// queue and the output register; while the receiver takes each item and no
// frame is sent, such commands flow at one per cycle. A set options frame
// yields CHANNEL_BITS+VALUE_BITS items: the first waits out select_setup_time
// and sck_half_period after the job leaves the queue, each further bit another
// sck_half_period, so the serializer's pacing counter sets the frame rate.
// When the receiver stalls, the output register holds its item, the queue
// fills and cmd_ready drops once four jobs wait. Reset empties the queue,
// disables all drivers, clears the other pins and loads the timing defaults.
// ----------------------------------------------------------------------------
module stepper_driver_pin_control #(
	parameter int NUM_AXES     = sdpc_pkg::NUM_AXES_DEF,
	parameter int CHANNEL_BITS = sdpc_pkg::CHANNEL_BITS_DEF,
	parameter int VALUE_BITS   = sdpc_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  sdpc_pkg::cmd_item_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output sdpc_pkg::res_item_t res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import sdpc_pkg::*;

	timing_t timing_q;
	q_status_t q_status;
	job_t push_job;
	job_t head;
	logic push;
	logic pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.sck_half_period <= SCK_HALF_PERIOD_RST;
			timing_q.select_setup_time <= SELECT_SETUP_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCK_HALF_PERIOD: timing_q.sck_half_period <= cfg_data;
				CFG_SELECT_SETUP_TIME: timing_q.select_setup_time <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sdpc_front #(
		.NUM_AXES(NUM_AXES),
		.CHANNEL_BITS(CHANNEL_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.q_status(q_status),
		.push(push),
		.push_job(push_job)
	);

	sdpc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.q_status(q_status)
	);

	sdpc_back #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_status(q_status),
		.pop(pop),
		.timing(timing_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

endmodule

// File: verif/stepper_driver_pin_control_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_driver_pin_control_tb: pin register and current frame check
// Sends pin commands and set options commands, predicts every pin item and
// every serial frame bit, and checks each accepted result against the oldest
// prediction. Timing registers move through several settings between phases.
// ----------------------------------------------------------------------------
module stepper_driver_pin_control_tb;
	import sdpc_pkg::*;

	localparam int AXES        = 5;
	localparam int FRAME_W     = 11;
	localparam int STALL_LIMIT = 200000;
	localparam int TAIL_CYCLES = 50;

	// Potentiometer channel of axes 0 to 4, three bits each, axis 0 lowest.
	localparam logic [14:0] AXIS_CHAN = {3'd5, 3'd2, 3'd0, 3'd1, 3'd3};

	localparam logic [2:0] MODE_UNUSED_LO = MODE_CLEAR_STEPS + 3'd1;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	cmd_item_t  cmd       = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_item_t  res;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predicted pin registers and timing registers.
	logic [4:0]  ms1_q, ms2_q, en_n_q, dir_q, step_q;
	logic [15:0] half_period_q, setup_q;

	cmd_item_t cmd_backlog[$];
	res_item_t awaited_res[$];
	res_item_t want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	stepper_driver_pin_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Applies one command to the predicted pins and queues the items it yields.
	function automatic void apply_command(input cmd_item_t c);
		logic               motor;
		logic [4:0]         sel;
		logic [FRAME_W-1:0] frame;
		res_item_t          r;
		motor = c.axis < AXES;
		sel = motor ? 5'(1 << c.axis) : 5'd0;
		if (c.mode == MODE_SET_OPTIONS && (motor || c.axis == AXIS_EXTRA)) begin
			if (motor && c.ustep_bits < USTEP_LIMIT) begin
				ms1_q = c.ustep_bits[0] ? (ms1_q | sel) : (ms1_q & ~sel);
				ms2_q = c.ustep_bits[1] ? (ms2_q | sel) : (ms2_q & ~sel);
			end
			frame = {motor ? AXIS_CHAN[3 * c.axis +: 3] : CHAN_EXTRA, c.current};
			for (int k = 0; k < FRAME_W; k++) begin
				r = '{ms1_q, ms2_q, en_n_q, dir_q, step_q,
					frame[FRAME_W-1-k], 1'b1, k == FRAME_W - 1};
				awaited_res.push_back(r);
			end
		end else begin
			case (c.mode)
				MODE_ENABLE: if (motor) en_n_q = c.level ? (en_n_q & ~sel) : (en_n_q | sel);
				MODE_DIRECTION: if (motor) dir_q = c.level ? (dir_q | sel) : (dir_q & ~sel);
				// The select mask is empty for an axis without a motor.
				MODE_STEP: step_q = step_q | sel;
				MODE_CLEAR_STEPS: step_q = '0;
				default: ;
			endcase
			r = '{ms1_q, ms2_q, en_n_q, dir_q, step_q, 1'b0, 1'b0, 1'b1};
			awaited_res.push_back(r);
		end
	endfunction

	function automatic cmd_item_t make_cmd(input logic [2:0] mode, input logic [2:0] axis,
			input logic [2:0] ustep, input logic [7:0] cur, input logic lvl);
		cmd_item_t c;
		c = '{mode, axis, ustep, cur, lvl};
		return c;
	endfunction

	function automatic cmd_item_t rand_cmd(input bit frames_ok);
		cmd_item_t c;
		int        pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			c.mode = MODE_SET_OPTIONS;
		else if (pick < 54)
			c.mode = MODE_ENABLE;
		else if (pick < 70)
			c.mode = MODE_DIRECTION;
		else if (pick < 86)
			c.mode = MODE_STEP;
		else if (pick < 93)
			c.mode = MODE_CLEAR_STEPS;
		else
			c.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		c.axis = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, AXES - 1))
			: 3'($urandom_range(AXES, 7));
		c.ustep_bits = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 9);
		c.current = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
		c.level = 1'($urandom_range(0, 1));
		if (!frames_ok && c.mode == MODE_SET_OPTIONS && (c.axis < AXES || c.axis == AXIS_EXTRA))
			c.axis = AXIS_EXTRA + 3'd1;
		return c;
	endfunction

	// Command sender: the prediction is made when an item is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_ready) begin
			if (cmd_valid)
				apply_command(cmd);
			if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cmd <= cmd_backlog.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (awaited_res.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result item %h", res);
					mismatches++;
				end else begin
					want = awaited_res.pop_front();
					if (res.ms1_pins !== want.ms1_pins || res.ms2_pins !== want.ms2_pins
							|| res.enable_n_pins !== want.enable_n_pins
							|| res.dir_pins !== want.dir_pins
							|| res.step_pins !== want.step_pins
							|| res.frame_bit !== want.frame_bit
							|| res.frame_valid !== want.frame_valid
							|| res.last !== want.last) begin
						if (mismatches < 10) begin
							$display("mismatch: expected ms1 %h ms2 %h en_n %h dir %h step %h bit %b valid %b last %b",
								want.ms1_pins, want.ms2_pins, want.enable_n_pins, want.dir_pins,
								want.step_pins, want.frame_bit, want.frame_valid, want.last);
							$display("          actual   ms1 %h ms2 %h en_n %h dir %h step %h bit %b valid %b last %b",
								res.ms1_pins, res.ms2_pins, res.enable_n_pins, res.dir_pins,
								res.step_pins, res.frame_bit, res.frame_valid, res.last);
						end
						mismatches++;
					end
				end
			end
			res_ready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	// Ends a hung run: counts cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SCK_HALF_PERIOD)
			half_period_q = val;
		else if (idx == CFG_SELECT_SETUP_TIME)
			setup_q = val;
	endtask

	// Waits until every command is accepted and every predicted item has come.
	task automatic drain();
		do @(posedge clk);
		while (cmd_backlog.size() != 0 || cmd_valid || awaited_res.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input bit frames_ok);
		repeat (n) cmd_backlog.push_back(rand_cmd(frames_ok));
		drain();
	endtask

	initial begin
		ms1_q = '0;
		ms2_q = '0;
		en_n_q = '1;
		dir_q = '0;
		step_q = '0;
		half_period_q = SCK_HALF_PERIOD_RST;
		setup_q = SELECT_SETUP_TIME_RST;
		send_idle_pct = 13;
		recv_idle_pct = 56;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Fastest serial timing for the directed commands.
		write_reg(CFG_SCK_HALF_PERIOD, 16'd1);
		write_reg(CFG_SELECT_SETUP_TIME, 16'd1);
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd0, 3'd1, 8'h00, 1'b0));
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd1, 3'd2, 8'hFF, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd2, 3'd3, 8'hA5, 1'b0));
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd3, 3'd0, 8'h5A, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd4, 3'd3, 8'h81, 1'b0));
		// The extra channel sends a frame but leaves the microstep pins alone.
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, AXIS_EXTRA, 3'd1, 8'h7E, 1'b0));
		// A microstep code of four or more still sends the frame.
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd2, 3'd7, 8'h3C, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd5, 3'd1, 8'hFF, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd7, 3'd2, 8'h00, 1'b0));
		cmd_backlog.push_back(make_cmd(MODE_ENABLE, 3'd0, 3'd0, 8'h00, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_ENABLE, 3'd4, 3'd7, 8'hFF, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_ENABLE, 3'd0, 3'd0, 8'h00, 1'b0));
		cmd_backlog.push_back(make_cmd(MODE_ENABLE, 3'd7, 3'd0, 8'h00, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_ENABLE, AXIS_EXTRA, 3'd0, 8'h00, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_DIRECTION, 3'd3, 3'd0, 8'h00, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_DIRECTION, 3'd1, 3'd0, 8'h00, 1'b0));
		cmd_backlog.push_back(make_cmd(MODE_DIRECTION, 3'd4, 3'd0, 8'h00, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_STEP, 3'd0, 3'd0, 8'h00, 1'b0));
		cmd_backlog.push_back(make_cmd(MODE_STEP, 3'd4, 3'd0, 8'h00, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_STEP, 3'd5, 3'd0, 8'h00, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_CLEAR_STEPS, 3'd2, 3'd5, 8'h11, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_UNUSED_LO, 3'd1, 3'd2, 8'h22, 1'b1));
		cmd_backlog.push_back(make_cmd(MODE_UNUSED_HI, 3'd3, 3'd1, 8'hEE, 1'b0));
		drain();

		write_reg(CFG_SCK_HALF_PERIOD, 16'd2);
		write_reg(CFG_SELECT_SETUP_TIME, 16'd7);
		run_phase(150, 1'b1);

		send_idle_pct = 56;
		recv_idle_pct = 13;
		write_reg(CFG_SCK_HALF_PERIOD, 16'($urandom_range(1, 8)));
		write_reg(CFG_SELECT_SETUP_TIME, 16'($urandom_range(1, 40)));
		run_phase(150, 1'b1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_SCK_HALF_PERIOD, 16'($urandom_range(1, 8)));
		write_reg(CFG_SELECT_SETUP_TIME, 16'($urandom_range(1, 40)));
		run_phase(150, 1'b1);

		// Slowest timing: a frame here would take far too long, so pin items only.
		write_reg(CFG_SCK_HALF_PERIOD, 16'hFFFF);
		write_reg(CFG_SELECT_SETUP_TIME, 16'hFFFF);
		// An index past the last register must be ignored.
		write_reg(CFG_SELECT_SETUP_TIME + 2'd1, 16'h0001);
		run_phase(10, 1'b0);

		// Longest chip select setup with one frame.
		write_reg(CFG_SCK_HALF_PERIOD, 16'd1);
		cmd_backlog.push_back(make_cmd(MODE_SET_OPTIONS, 3'd4, 3'd3, 8'hFF, 1'b1));
		run_phase(4, 1'b0);

		repeat (TAIL_CYCLES + 2 * half_period_q) @(posedge clk);
		if (mismatches == 0 && awaited_res.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
